@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl of the input qualifier
// synthesis builds define SYNTHESIS and get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/bidq_pkg.sv @@
// types and codes of the button input debounce qualifier
// no dependencies
`timescale 1ns / 1ps

package bidq_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_EDGE    = 2'd1,
        PH_QUAL    = 2'd2,
        PH_PRESSED = 2'd3
    } phase_t;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [2:0] KIND_UNUSED      = 3'd0;
    localparam logic [2:0] KIND_BUTTON      = 3'd1;
    localparam logic [2:0] KIND_BUTTON_HILO = 3'd2;
    localparam logic [2:0] KIND_SWITCH      = 3'd3;
    localparam logic [2:0] KIND_SENSOR      = 3'd4;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_RELAY_ON   = 3'd1;
    localparam logic [2:0] ACT_RELAY_OFF  = 3'd2;
    localparam logic [2:0] ACT_RELAY_TGL  = 3'd3;
    localparam logic [2:0] ACT_REPORT_ON  = 3'd4;
    localparam logic [2:0] ACT_REPORT_OFF = 3'd5;

    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_CFG     = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [2:0] REG_INPUT_KIND     = 3'd0;
    localparam logic [2:0] REG_ACTIVE_LOW     = 3'd1;
    localparam logic [2:0] REG_CONFIG_BUTTON  = 3'd2;
    localparam logic [2:0] REG_RELAY_PRESENT  = 3'd3;
    localparam logic [2:0] REG_CHAN_PRESENT   = 3'd4;
    localparam logic [2:0] REG_MIN_STABLE     = 3'd5;
    localparam logic [2:0] REG_LONG_PRESS     = 3'd6;
    localparam logic [2:0] REG_SWITCH_TOGGLES = 3'd7;

    localparam logic [31:0] SWITCH_GAP_US = 32'd2000000;
    localparam logic [7:0]  SAT_MAX       = 8'hFF;

    typedef struct packed {
        logic [2:0] input_kind;
        logic       active_low;
        logic       config_button;
        logic       relay_present;
        logic       channel_present;
        logic [7:0] min_stable_ticks;
        logic [7:0] long_press_ticks;
        logic [7:0] switch_toggles_for_cfg;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic        pin_level;
        logic        cfg_mode_on;
        logic [31:0] time_us;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] system_request;
        logic       sampling_on;
    } result_t;

endpackage

@@ rtl/core/bidq_step.sv @@
// qualifier state and its per-item update: phase, sampling arm, counters
// depends on bidq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bidq_step
(
    input  logic             clk,
    input  logic             rst_n,
    input  bidq_pkg::cfg_t   cfg,
    input  logic             fire,
    input  bidq_pkg::item_t  item,
    output bidq_pkg::result_t result
);

    bidq_pkg::phase_t phase_reg, phase_next;
    logic        armed_reg, armed_next;
    logic [7:0]  stable_count_reg, stable_count_next;
    logic [7:0]  cfg_count_reg, cfg_count_next;
    logic [31:0] last_active_time_reg, last_active_time_next;

    logic        kind_ok;
    logic        is_button;
    logic        is_switch;
    logic        active;
    logic        finish;
    logic [7:0]  stable_inc;
    logic [7:0]  cfg_inc;
    logic [31:0] gap;
    logic [2:0]  press_act;
    logic [2:0]  release_act;

    assign kind_ok   = (cfg.input_kind >= bidq_pkg::KIND_BUTTON) &&
                       (cfg.input_kind <= bidq_pkg::KIND_SENSOR);
    assign is_button = (cfg.input_kind == bidq_pkg::KIND_BUTTON) ||
                       (cfg.input_kind == bidq_pkg::KIND_BUTTON_HILO);
    assign is_switch = (cfg.input_kind == bidq_pkg::KIND_SWITCH);
    assign active    = (item.pin_level == !cfg.active_low);
    assign stable_inc = (stable_count_reg == bidq_pkg::SAT_MAX) ? stable_count_reg
                                                               : stable_count_reg + 8'd1;
    assign cfg_inc   = (cfg_count_reg == bidq_pkg::SAT_MAX) ? cfg_count_reg
                                                           : cfg_count_reg + 8'd1;
    assign gap       = item.time_us - last_active_time_reg;

    always_comb
    begin
        priority if (cfg.input_kind == bidq_pkg::KIND_BUTTON_HILO)
            press_act = cfg.relay_present ? bidq_pkg::ACT_RELAY_ON : bidq_pkg::ACT_NONE;
        else if (is_switch)
            press_act = cfg.relay_present ? bidq_pkg::ACT_RELAY_TGL : bidq_pkg::ACT_NONE;
        else if (cfg.input_kind == bidq_pkg::KIND_SENSOR)
            press_act = cfg.channel_present ? bidq_pkg::ACT_REPORT_ON : bidq_pkg::ACT_NONE;
        else
            press_act = bidq_pkg::ACT_NONE;

        priority if (cfg.input_kind == bidq_pkg::KIND_BUTTON_HILO)
            release_act = cfg.relay_present ? bidq_pkg::ACT_RELAY_OFF : bidq_pkg::ACT_NONE;
        else if ((cfg.input_kind == bidq_pkg::KIND_BUTTON) || is_switch)
            release_act = cfg.relay_present ? bidq_pkg::ACT_RELAY_TGL : bidq_pkg::ACT_NONE;
        else if (cfg.input_kind == bidq_pkg::KIND_SENSOR)
            release_act = cfg.channel_present ? bidq_pkg::ACT_REPORT_OFF
                                              : bidq_pkg::ACT_NONE;
        else
            release_act = bidq_pkg::ACT_NONE;
    end

    always_comb
    begin
        phase_next            = phase_reg;
        armed_next            = armed_reg;
        stable_count_next     = stable_count_reg;
        cfg_count_next        = cfg_count_reg;
        last_active_time_next = last_active_time_reg;
        result.action         = bidq_pkg::ACT_NONE;
        result.system_request = bidq_pkg::REQ_NONE;
        finish                = 1'b0;

        if (item.operation == bidq_pkg::OP_EDGE)
        begin
            if (kind_ok && ((phase_reg == bidq_pkg::PH_IDLE) ||
                            (phase_reg == bidq_pkg::PH_PRESSED)))
            begin
                if (phase_reg == bidq_pkg::PH_IDLE)
                    phase_next = bidq_pkg::PH_EDGE;
                armed_next = 1'b1;
            end
        end
        else if (armed_reg)
        begin
            finish = 1'b1;
            unique case (phase_reg)
                bidq_pkg::PH_IDLE:
                begin
                end
                bidq_pkg::PH_EDGE:
                begin
                    if (active)
                    begin
                        stable_count_next = 8'd1;
                        if (cfg.config_button &&
                            (is_button || (gap >= bidq_pkg::SWITCH_GAP_US)))
                            cfg_count_next = 8'd0;
                        phase_next = bidq_pkg::PH_QUAL;
                        finish     = 1'b0;
                    end
                end
                bidq_pkg::PH_QUAL, bidq_pkg::PH_PRESSED:
                begin
                    stable_count_next = stable_inc;
                    if (active)
                    begin
                        finish = 1'b0;
                        // held configuration button counts toward a long press
                        if ((phase_reg == bidq_pkg::PH_PRESSED) && cfg.config_button &&
                            is_button)
                        begin
                            cfg_count_next = cfg_inc;
                            if (cfg_inc >= cfg.long_press_ticks)
                            begin
                                if (!item.cfg_mode_on)
                                    result.system_request = bidq_pkg::REQ_CFG;
                                finish = 1'b1;
                            end
                        end
                        if ((phase_reg == bidq_pkg::PH_QUAL) &&
                            (stable_inc >= cfg.min_stable_ticks))
                        begin
                            result.action = press_act;
                            if (!cfg.config_button || is_switch)
                                armed_next = 1'b0;
                            stable_count_next     = 8'd1;
                            last_active_time_next = item.time_us;
                            phase_next            = bidq_pkg::PH_PRESSED;
                        end
                    end
                    else if (phase_reg == bidq_pkg::PH_PRESSED)
                    begin
                        if (stable_inc >= cfg.min_stable_ticks)
                        begin
                            if (cfg.config_button && is_switch)
                            begin
                                cfg_count_next = cfg_inc;
                                if (!item.cfg_mode_on)
                                begin
                                    if (cfg_inc >= cfg.switch_toggles_for_cfg)
                                    begin
                                        cfg_count_next        = 8'd0;
                                        result.system_request = bidq_pkg::REQ_CFG;
                                    end
                                end
                                else if (cfg_inc > 8'd2)
                                    result.system_request = bidq_pkg::REQ_RESTART;
                            end
                            if (cfg.config_button && item.cfg_mode_on && is_button)
                                result.system_request = bidq_pkg::REQ_RESTART;
                            else
                                result.action = release_act;
                        end
                        else
                            finish = 1'b0;
                    end
                end
            endcase
            if (finish)
            begin
                phase_next = bidq_pkg::PH_IDLE;
                armed_next = 1'b0;
            end
        end
        result.sampling_on = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= bidq_pkg::PH_IDLE;
            armed_reg            <= 1'b0;
            stable_count_reg     <= 8'd0;
            cfg_count_reg        <= 8'd0;
            last_active_time_reg <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg            <= phase_next;
            armed_reg            <= armed_next;
            stable_count_reg     <= stable_count_next;
            cfg_count_reg        <= cfg_count_next;
            last_active_time_reg <= last_active_time_next;
        end
    end

    // sampling is never armed with the phase back at idle
    `ASSERT_IMPL(a_idle_unarmed, clk, rst_n, phase_reg == bidq_pkg::PH_IDLE, !armed_reg)
    // a qualifying or pressed level has been seen for at least one tick
    `ASSERT_IMPL(a_stable_nonzero, clk, rst_n,
                 (phase_reg == bidq_pkg::PH_QUAL) || (phase_reg == bidq_pkg::PH_PRESSED),
                 stable_count_reg != 8'd0)
    // edge events never produce an action or a request
    `ASSERT_IMPL(a_edge_quiet, clk, rst_n,
                 fire && (item.operation == bidq_pkg::OP_EDGE),
                 (result.action == bidq_pkg::ACT_NONE) &&
                 (result.system_request == bidq_pkg::REQ_NONE))

endmodule

@@ rtl/core/button_input_debounce_qualifier.sv @@
// channel    | dir | handshake         | payload
// s_         | in  | tvalid / tready   | tuser: operation; tdata: pin, cfg mode, time
// m_         | out | tvalid / tready   | tdata: action, system request, sampling on
// cfg_       | in  | cfg_we, no wait   | cfg_index selects register, cfg_data value
// one transfer per cycle when not stalled: input register, state update, result register
// an item moves from the input register through the state update to the result register
// rst_n clears the state and loads the register defaults
// a stalled result holds the update stage; an empty input register still takes one more
// depends on bidq_pkg, bidq_step and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_input_debounce_qualifier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // [0] operation
    input  logic [39:0] s_tdata,    // [0] pin_level, [1] cfg_mode_on, [33:2] time_us
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [2:0] action, [4:3] system_request, [5] sampling_on
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    bidq_pkg::cfg_t    cfg_reg;
    bidq_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    bidq_pkg::result_t out_data_reg;
    logic              out_valid_reg;
    bidq_pkg::result_t step_result;
    logic              out_free;
    logic              fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_kind             <= bidq_pkg::KIND_UNUSED;
            cfg_reg.active_low             <= 1'b0;
            cfg_reg.config_button          <= 1'b0;
            cfg_reg.relay_present          <= 1'b0;
            cfg_reg.channel_present        <= 1'b0;
            cfg_reg.min_stable_ticks       <= 8'd5;
            cfg_reg.long_press_ticks       <= 8'd250;
            cfg_reg.switch_toggles_for_cfg <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bidq_pkg::REG_INPUT_KIND:     cfg_reg.input_kind       <= cfg_data[2:0];
                bidq_pkg::REG_ACTIVE_LOW:     cfg_reg.active_low       <= cfg_data[0];
                bidq_pkg::REG_CONFIG_BUTTON:  cfg_reg.config_button    <= cfg_data[0];
                bidq_pkg::REG_RELAY_PRESENT:  cfg_reg.relay_present    <= cfg_data[0];
                bidq_pkg::REG_CHAN_PRESENT:   cfg_reg.channel_present  <= cfg_data[0];
                bidq_pkg::REG_MIN_STABLE:     cfg_reg.min_stable_ticks <= cfg_data;
                bidq_pkg::REG_LONG_PRESS:     cfg_reg.long_press_ticks <= cfg_data;
                bidq_pkg::REG_SWITCH_TOGGLES: cfg_reg.switch_toggles_for_cfg <= cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.operation   <= s_tuser;
            in_item_reg.pin_level   <= s_tdata[0];
            in_item_reg.cfg_mode_on <= s_tdata[1];
            in_item_reg.time_us     <= s_tdata[33:2];
        end
    end

    bidq_step u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fire   (fire),
        .item   (in_item_reg),
        .result (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.sampling_on, out_data_reg.system_request,
                       out_data_reg.action};

    // input side only stalls behind a held item
    `ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !s_tready, in_valid_reg)
    // an item that cannot move on stays in the input register
    `ASSERT_NEXT(a_item_kept, clk, rst_n, in_valid_reg && !out_free, in_valid_reg)
    // an item that moves on shows up as a result in the next cycle
    `ASSERT_NEXT(a_result_follows, clk, rst_n, fire, m_tvalid)

endmodule

@@ dv/tb_button_input_debounce_qualifier.sv @@
`timescale 1ns / 1ps
// self-checking bench for button_input_debounce_qualifier: directed press and release
// gestures, then randomized gestures and noise under random idling on both streams
// depends on bidq_pkg and the rtl of the qualifier

module tb_button_input_debounce_qualifier;

    localparam int HALF_PERIOD   = 10;
    localparam int HOLD_CYCLES   = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tuser;    // [0] operation
    logic [39:0] s_tdata;    // [0] pin_level, [1] cfg_mode_on, [33:2] time_us
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [2:0] action, [4:3] system_request, [5] sampling_on
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    // local copy of the qualifier registers and state
    bidq_pkg::cfg_t   regs;
    bidq_pkg::phase_t ph;
    logic        armed;
    logic [7:0]  stable_cnt;
    logic [7:0]  cfg_cnt;
    logic [31:0] last_press_us;

    bidq_pkg::result_t pending_results[$];
    bidq_pkg::result_t want;
    logic [31:0] now_us;
    int          items_sent;
    int          mismatches;
    int          stall_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_req;

    button_input_debounce_qualifier DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bidq_pkg::cfg_t make_cfg(input logic [2:0] kind, input logic act_low,
                                      input logic cfg_btn, input logic relay,
                                      input logic chan, input logic [7:0] min_ticks,
                                      input logic [7:0] long_ticks, input logic [7:0] toggles);
        bidq_pkg::cfg_t c;
        c.input_kind             = kind;
        c.active_low             = act_low;
        c.config_button          = cfg_btn;
        c.relay_present          = relay;
        c.channel_present        = chan;
        c.min_stable_ticks       = min_ticks;
        c.long_press_ticks       = long_ticks;
        c.switch_toggles_for_cfg = toggles;
        return c;
    endfunction

    function automatic bidq_pkg::cfg_t random_cfg();
        bidq_pkg::cfg_t c;
        c.input_kind = ($urandom_range(7) == 0) ? 3'($urandom_range(7))
                                                : 3'($urandom_range(4, 1));
        c.active_low      = 1'($urandom_range(1));
        c.config_button   = ($urandom_range(3) != 0);
        c.relay_present   = ($urandom_range(3) != 0);
        c.channel_present = ($urandom_range(3) != 0);
        c.min_stable_ticks = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(4, 1));
        c.long_press_ticks = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                      : 8'($urandom_range(6, 1));
        c.switch_toggles_for_cfg = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                            : 8'($urandom_range(3, 1));
        return c;
    endfunction

    // debounce, long press and toggle counting for one accepted transfer
    function automatic bidq_pkg::result_t qualify_item(input logic op, input logic lvl,
                                             input logic cfg_on, input logic [31:0] t_us);
        bidq_pkg::result_t res;
        logic        is_button;
        logic        active;
        logic        finish;
        logic [31:0] since_press;
        res.action         = bidq_pkg::ACT_NONE;
        res.system_request = bidq_pkg::REQ_NONE;
        is_button   = (regs.input_kind == bidq_pkg::KIND_BUTTON) ||
                      (regs.input_kind == bidq_pkg::KIND_BUTTON_HILO);
        since_press = t_us - last_press_us;
        if (op == bidq_pkg::OP_EDGE)
        begin
            if (regs.input_kind >= bidq_pkg::KIND_BUTTON
                && regs.input_kind <= bidq_pkg::KIND_SENSOR
                && (ph == bidq_pkg::PH_IDLE || ph == bidq_pkg::PH_PRESSED))
            begin
                if (ph == bidq_pkg::PH_IDLE)
                    ph = bidq_pkg::PH_EDGE;
                armed = 1'b1;
            end
        end
        else if (armed)
        begin
            active = (lvl != regs.active_low);
            finish = 1'b1;
            if (ph == bidq_pkg::PH_EDGE)
            begin
                if (active)
                begin
                    stable_cnt = 8'd1;
                    // a switch keeps its toggle count across short gaps
                    if (regs.config_button &&
                        (is_button || since_press >= bidq_pkg::SWITCH_GAP_US))
                        cfg_cnt = 8'd0;
                    ph     = bidq_pkg::PH_QUAL;
                    finish = 1'b0;
                end
            end
            else if (ph != bidq_pkg::PH_IDLE)
            begin
                if (stable_cnt != bidq_pkg::SAT_MAX)
                    stable_cnt++;
                if (active)
                begin
                    finish = 1'b0;
                    if (ph == bidq_pkg::PH_PRESSED && regs.config_button && is_button)
                    begin
                        if (cfg_cnt != bidq_pkg::SAT_MAX)
                            cfg_cnt++;
                        if (cfg_cnt >= regs.long_press_ticks)
                        begin
                            if (!cfg_on)
                                res.system_request = bidq_pkg::REQ_CFG;
                            finish = 1'b1;
                        end
                    end
                    if (!finish && ph == bidq_pkg::PH_QUAL &&
                        stable_cnt >= regs.min_stable_ticks)
                    begin
                        case (regs.input_kind)
                            bidq_pkg::KIND_BUTTON_HILO:
                                res.action = regs.relay_present ? bidq_pkg::ACT_RELAY_ON
                                                                : bidq_pkg::ACT_NONE;
                            bidq_pkg::KIND_SWITCH:
                                res.action = regs.relay_present ? bidq_pkg::ACT_RELAY_TGL
                                                                : bidq_pkg::ACT_NONE;
                            bidq_pkg::KIND_SENSOR:
                                res.action = regs.channel_present ? bidq_pkg::ACT_REPORT_ON
                                                                  : bidq_pkg::ACT_NONE;
                            default:
                                res.action = bidq_pkg::ACT_NONE;
                        endcase
                        if (!regs.config_button || regs.input_kind == bidq_pkg::KIND_SWITCH)
                            armed = 1'b0;
                        stable_cnt    = 8'd1;
                        last_press_us = t_us;
                        ph            = bidq_pkg::PH_PRESSED;
                    end
                end
                else if (ph == bidq_pkg::PH_PRESSED)
                begin
                    if (stable_cnt >= regs.min_stable_ticks)
                    begin
                        if (regs.config_button && regs.input_kind == bidq_pkg::KIND_SWITCH)
                        begin
                            if (cfg_cnt != bidq_pkg::SAT_MAX)
                                cfg_cnt++;
                            if (!cfg_on)
                            begin
                                if (cfg_cnt >= regs.switch_toggles_for_cfg)
                                begin
                                    cfg_cnt            = 8'd0;
                                    res.system_request = bidq_pkg::REQ_CFG;
                                end
                            end
                            else if (cfg_cnt > 8'd2)
                                res.system_request = bidq_pkg::REQ_RESTART;
                        end
                        if (regs.config_button && cfg_on && is_button)
                            res.system_request = bidq_pkg::REQ_RESTART;
                        else
                        begin
                            case (regs.input_kind)
                                bidq_pkg::KIND_BUTTON_HILO:
                                    res.action = regs.relay_present ? bidq_pkg::ACT_RELAY_OFF
                                                                    : bidq_pkg::ACT_NONE;
                                bidq_pkg::KIND_BUTTON,
                                bidq_pkg::KIND_SWITCH:
                                    res.action = regs.relay_present ? bidq_pkg::ACT_RELAY_TGL
                                                                    : bidq_pkg::ACT_NONE;
                                bidq_pkg::KIND_SENSOR:
                                    res.action = regs.channel_present
                                                 ? bidq_pkg::ACT_REPORT_OFF
                                                 : bidq_pkg::ACT_NONE;
                                default:
                                    res.action = bidq_pkg::ACT_NONE;
                            endcase
                        end
                    end
                    else
                        finish = 1'b0;
                end
            end
            if (finish)
            begin
                ph    = bidq_pkg::PH_IDLE;
                armed = 1'b0;
            end
        end
        res.sampling_on = armed;
        return res;
    endfunction

    // mostly one sampling period, now and then a long gap or almost none
    function automatic logic [31:0] advance_clock();
        case ($urandom_range(9))
            0:       now_us += $urandom_range(3000000, 2000000);
            1:       now_us += $urandom_range(100);
            default: now_us += 32'd20000;
        endcase
        return now_us;
    endfunction

    // input side: predict at every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_results.push_back(qualify_item(s_tuser, s_tdata[0], s_tdata[1],
                                                   s_tdata[33:2]));
    end

    // output side: compare against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with none expected: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[4:3] !== want.system_request)
                begin
                    $error("system_request: expected %0d, got %0d",
                           want.system_request, m_tdata[4:3]);
                    mismatches++;
                end
                if (m_tdata[5] !== want.sampling_on)
                begin
                    $error("sampling_on: expected %0d, got %0d", want.sampling_on, m_tdata[5]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result receiver with random idling and an occasional long hold-off
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic op, input logic lvl, input logic cfg_on,
                             input logic [31:0] t_us);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, t_us, cfg_on, lvl};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_edge(input logic lvl, input logic cfg_on);
        send_item(bidq_pkg::OP_EDGE, lvl, cfg_on, advance_clock());
    endtask

    task automatic send_tick(input logic lvl, input logic cfg_on);
        send_item(bidq_pkg::OP_TICK, lvl, cfg_on, advance_clock());
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_config(input bidq_pkg::cfg_t c);
        wait_results_done();
        write_reg(bidq_pkg::REG_INPUT_KIND, {5'b0, c.input_kind});
        write_reg(bidq_pkg::REG_ACTIVE_LOW, {7'b0, c.active_low});
        write_reg(bidq_pkg::REG_CONFIG_BUTTON, {7'b0, c.config_button});
        write_reg(bidq_pkg::REG_RELAY_PRESENT, {7'b0, c.relay_present});
        write_reg(bidq_pkg::REG_CHAN_PRESENT, {7'b0, c.channel_present});
        write_reg(bidq_pkg::REG_MIN_STABLE, c.min_stable_ticks);
        write_reg(bidq_pkg::REG_LONG_PRESS, c.long_press_ticks);
        write_reg(bidq_pkg::REG_SWITCH_TOGGLES, c.switch_toggles_for_cfg);
        cfg_we <= 1'b0;
        regs = c;
    endtask

    // edge, optional bounce, a held level, usually a release edge, then release ticks
    task automatic run_gesture(input logic cfg_on);
        logic on_lvl;
        int   hold_max;
        int   rel_max;
        on_lvl   = !regs.active_low;
        hold_max = int'(regs.min_stable_ticks) + int'(regs.long_press_ticks) + 2;
        if (hold_max > 14)
            hold_max = 14;
        rel_max = int'(regs.min_stable_ticks) + 2;
        if (rel_max > 8)
            rel_max = 8;
        send_edge(1'($urandom_range(1)), cfg_on);
        if ($urandom_range(3) == 0)
            send_tick(!on_lvl, cfg_on);
        repeat ($urandom_range(hold_max, 1)) send_tick(on_lvl, cfg_on);
        if ($urandom_range(4) != 0)
            send_edge(1'($urandom_range(1)), cfg_on);
        repeat ($urandom_range(rel_max, 1)) send_tick(!on_lvl, cfg_on);
    endtask

    // unused kind after reset: edges and ticks give nothing
    task automatic test_reset_defaults();
        send_item(bidq_pkg::OP_EDGE, 1'b1, 1'b0, 32'h0000_0000);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_item(bidq_pkg::OP_TICK, 1'b0, 1'b1, 32'h0000_4E20);
        send_item(bidq_pkg::OP_EDGE, 1'b0, 1'b1, 32'h0000_9C40);
    endtask

    task automatic test_directed();
        // configuration button: long press asks for config mode, release in it restarts
        apply_config(make_cfg(bidq_pkg::KIND_BUTTON, 1'b0, 1'b1, 1'b1, 1'b0,
                              8'd1, 8'd2, 8'd1));
        send_item(bidq_pkg::OP_EDGE, 1'b0, 1'b0, 32'h0000_0000);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h0000_4E20);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h0000_9C40);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h0000_EA60);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h0001_3880);
        send_item(bidq_pkg::OP_EDGE, 1'b1, 1'b1, 32'h0001_86A0);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b1, 32'h0001_D4C0);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b1, 32'h0002_22E0);
        send_item(bidq_pkg::OP_TICK, 1'b0, 1'b1, 32'h0002_7100);
        // active-low switch with zero stable ticks and a release edge
        apply_config(make_cfg(bidq_pkg::KIND_SWITCH, 1'b1, 1'b1, 1'b1, 1'b0,
                              8'd0, 8'd0, 8'd1));
        send_item(bidq_pkg::OP_EDGE, 1'b1, 1'b0, 32'hFFFF_FFF0);
        send_item(bidq_pkg::OP_TICK, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(bidq_pkg::OP_TICK, 1'b0, 1'b0, 32'h0000_4E1F);
        send_item(bidq_pkg::OP_EDGE, 1'b1, 1'b0, 32'h0000_9C3F);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h0000_EA5F);
        // sensor reports without configuration rights
        apply_config(make_cfg(bidq_pkg::KIND_SENSOR, 1'b0, 1'b0, 1'b0, 1'b1,
                              8'd1, 8'd1, 8'd1));
        send_item(bidq_pkg::OP_EDGE, 1'b0, 1'b0, 32'h1000_0000);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h1000_4E20);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h1000_9C40);
        send_item(bidq_pkg::OP_EDGE, 1'b0, 1'b0, 32'h1000_EA60);
        send_item(bidq_pkg::OP_TICK, 1'b0, 1'b0, 32'h1001_3880);
        // unknown kind ignores edges
        apply_config(make_cfg(3'd7, 1'b0, 1'b1, 1'b1, 1'b1, 8'd1, 8'd1, 8'd1));
        send_item(bidq_pkg::OP_EDGE, 1'b1, 1'b0, 32'h2000_0000);
        send_item(bidq_pkg::OP_TICK, 1'b1, 1'b0, 32'h2000_4E20);
    endtask

    // long receiver hold-off while gestures keep coming, then a full pause
    task automatic test_output_stall();
        apply_config(make_cfg(bidq_pkg::KIND_BUTTON_HILO, 1'b1, 1'b0, 1'b1, 1'b1,
                              8'd2, 8'd3, 8'd2));
        hold_req = 1'b1;
        repeat (4) run_gesture(1'b0);
        wait_results_done();
    endtask

    task automatic test_threshold_extremes();
        // counters run all the way up to 255
        apply_config(make_cfg(bidq_pkg::KIND_BUTTON, 1'b0, 1'b1, 1'b1, 1'b0,
                              8'd3, 8'd255, 8'd255));
        send_edge(1'b1, 1'b0);
        repeat (262) send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        apply_config(make_cfg(bidq_pkg::KIND_SWITCH, 1'b0, 1'b1, 1'b1, 1'b1,
                              8'd0, 8'd0, 8'd0));
        repeat (3) run_gesture(1'b1);
        repeat (2) run_gesture(1'b0);
    endtask

    task automatic test_random_gestures(input int send_pct, input int recv_pct);
        int   target;
        logic mode_on;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3)
        begin
            apply_config(random_cfg());
            mode_on = 1'($urandom_range(1));
            target  = items_sent + 30;
            while (items_sent < target)
            begin
                if ($urandom_range(4) == 0)
                    send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), $urandom());
                else
                    run_gesture(mode_on ^ ($urandom_range(3) == 0));
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        hold_req      = 1'b0;
        items_sent    = 0;
        mismatches    = 0;
        stall_cycles  = 0;
        send_idle_pct = 30;
        recv_idle_pct = 50;
        now_us        = $urandom();
        regs          = make_cfg(bidq_pkg::KIND_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0,
                                 8'd5, 8'd250, 8'd10);
        ph            = bidq_pkg::PH_IDLE;
        armed         = 1'b0;
        stable_cnt    = 8'd0;
        cfg_cnt       = 8'd0;
        last_press_us = 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_output_stall();
        test_random_gestures(30, 50);
        send_idle_pct = 50;
        recv_idle_pct = 30;
        test_threshold_extremes();
        test_random_gestures(50, 30);
        test_random_gestures(0, 0);
        wait_results_done();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
